[rtl/core/selective_repeat_receiver_unit_assert.svh]
// Assertion helpers used by the receiver RTL.
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("receiver assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("receiver assertion failed");

`endif

[rtl/core/srr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

  // Field widths
  localparam int SEQ_W  = 3;
  localparam int DATA_W = 64;

  // Parameter defaults
  localparam int WINDOW_DEF    = 4;
  localparam int SEQ_SPACE_DEF = 8;

  // Result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Arriving packet
  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic              checksum_ok;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  // Ack or delivered word
  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  ack_num;
    logic [DATA_W-1:0] data_out;
    logic              last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/srr_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one payload item per transfer.
interface srr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/srr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/selective_repeat_receiver_unit.sv]
// An accepted packet's ack is registered and on the output in the cycle after its transfer.
// Each delivered word is a read of the payload RAM read port followed by a load into the
//   output register; a load waits while the output is stalled.
// No new packet is accepted while words are delivered or the output is held.
// Reset (async, active low) clears all received marks at once and sets the base to 1.
`timescale 1ns / 1ps
`default_nettype none

`include "selective_repeat_receiver_unit_assert.svh"

module selective_repeat_receiver_unit #(
  parameter int WINDOW    = srr_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srr_chan_if.sink   in_i,
  srr_chan_if.source out_o
);

  import srr_pkg::*;

  localparam int BASE_W = $clog2(SEQ_SPACE);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int M1_W   = (SEQ_W > BASE_W) ? SEQ_W : BASE_W;
  localparam int M2_W   = (M1_W > CNT_W) ? M1_W : CNT_W;
  localparam int CW     = M2_W + 1;
  localparam int PREV_LO = (SEQ_SPACE > WINDOW) ? (SEQ_SPACE - WINDOW) : 0;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [WINDOW-1:0]   rcv_q, rcv_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic              in_fire, out_free, take, in_win, in_prev, do_ack;
  logic              new_store, start_dlv, dlv_load, next_rcv, ram_re;
  logic [CW-1:0]     seq_x, sum_x, dist_x;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_idx, head_nxt;
  logic [BASE_W-1:0] base_nxt;
  logic [DATA_W-1:0] ram_rdata;

  // Window classification of the arriving packet
  always_comb begin
    seq_x   = CW'(in_i.data.seq_num);
    sum_x   = seq_x + CW'(SEQ_SPACE) - CW'(base_q);
    dist_x  = (sum_x >= CW'(SEQ_SPACE)) ? (sum_x - CW'(SEQ_SPACE)) : sum_x;
    take    = in_i.data.checksum_ok && (seq_x < CW'(SEQ_SPACE));
    in_win  = dist_x < CW'(WINDOW);
    in_prev = !in_win && (dist_x >= CW'(PREV_LO));
    do_ack  = take && (in_win || in_prev);
  end

  // Buffer slot of the packet, relative to the head slot
  always_comb begin
    slot_sum = {1'b0, head_q} + dist_x[SLOT_W:0];
    slot_idx = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
               SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
  end

  // Next head slot and next base
  assign head_nxt = (head_q == SLOT_W'(WINDOW - 1)) ? '0 : (head_q + 1'b1);
  assign base_nxt = (base_q == BASE_W'(SEQ_SPACE - 1)) ? '0 : (base_q + 1'b1);
  assign next_rcv = rcv_q[head_nxt] && (head_nxt != head_q);

  // Handshakes
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign new_store   = in_fire && take && in_win && !rcv_q[slot_idx];
  assign start_dlv   = in_fire && take && in_win && (dist_x == '0);
  assign dlv_load    = (state_q == S_LOAD) && out_free;
  assign ram_re      = (state_q == S_READ);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Payload buffer
  srr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (new_store),
    .waddr_i (slot_idx),
    .wdata_i (in_i.data.payload),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: ack on transfer, then read/load per delivered word
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    head_d      = head_q;
    rcv_d       = rcv_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (new_store) begin
          rcv_d[slot_idx] = 1'b1;
        end
        if (in_fire && do_ack) begin
          out_valid_d         = 1'b1;
          out_data_d.kind     = KIND_ACK;
          out_data_d.ack_num  = in_i.data.seq_num;
          out_data_d.data_out = '0;
          out_data_d.last     = !start_dlv;
        end
        if (start_dlv) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.kind     = KIND_DATA;
          out_data_d.ack_num  = '0;
          out_data_d.data_out = ram_rdata;
          out_data_d.last     = !next_rcv;
          rcv_d[head_q]       = 1'b0;
          head_d              = head_nxt;
          base_d              = base_nxt;
          state_d             = next_rcv ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= BASE_W'(1 % SEQ_SPACE);
      head_q      <= '0;
      rcv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      head_q      <= head_d;
      rcv_q       <= rcv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // A delivered word always comes from a slot marked received
  `SRR_ASSERT_IMPL(a_load_rcv, clk_i, rst_ni, state_q == S_LOAD, rcv_q[head_q])
  // An ack not marked last is always followed by a delivery read
  `SRR_ASSERT_NEXT(a_ack_cont, clk_i, rst_ni, in_fire && start_dlv, state_q == S_READ)
  // A delivery not marked last leads to another read
  `SRR_ASSERT_NEXT(a_dlv_cont, clk_i, rst_ni, dlv_load && next_rcv, state_q == S_READ)
  // The new head slot is empty right after a last delivery, in the one-slot case too
  `SRR_ASSERT_NEXT(a_dlv_clear, clk_i, rst_ni, dlv_load && !next_rcv, !rcv_q[head_q])

endmodule

`default_nettype wire

[dv/tb_selective_repeat_receiver_unit.sv]
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_unit;
  import srr_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int SPACE       = SEQ_SPACE_DEF;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 85;
  // sender gap and receiver stall odds (percent) per random phase
  localparam int PHASE_GAP   [PHASES] = '{0, 35, 0, 40};
  localparam int PHASE_STALL [PHASES] = '{0, 0, 45, 35};

  // Tracks the receive window and queues the acks and deliveries it implies
  class arq_scoreboard;
    int unsigned       rx_base;
    bit                slot_full [WIN];
    logic [DATA_W-1:0] slot_word [WIN];
    out_item_t         pending_results [$];
    int                errors;

    function new();
      rx_base = 1 % SPACE;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      errors = 0;
    endfunction

    function void push_result(logic kind, logic [SEQ_W-1:0] ack, logic [DATA_W-1:0] word);
      out_item_t r;
      r.kind     = kind;
      r.ack_num  = ack;
      r.data_out = word;
      r.last     = 1'b0;
      pending_results = {pending_results, r};
    endfunction

    // Called once per accepted packet transfer
    function void note_packet(in_item_t p);
      int unsigned rel_pos;
      int unsigned n_before;
      n_before = pending_results.size();
      if (!p.checksum_ok) return;
      rel_pos = (int'(p.seq_num) + SPACE - rx_base) % SPACE;
      if (rel_pos < WIN) begin
        push_result(KIND_ACK, p.seq_num, '0);
        // duplicates keep the first payload
        if (!slot_full[rel_pos]) begin
          slot_full[rel_pos] = 1'b1;
          slot_word[rel_pos] = p.payload;
        end
        // base hit: drain the contiguous head of the window
        if (rel_pos == 0) begin
          while (slot_full[0]) begin
            push_result(KIND_DATA, '0, slot_word[0]);
            for (int i = 0; i + 1 < WIN; i++) begin
              slot_full[i] = slot_full[i+1];
              slot_word[i] = slot_word[i+1];
            end
            slot_full[WIN-1] = 1'b0;
            rx_base = (rx_base + 1) % SPACE;
          end
        end
      end else if (rel_pos >= SPACE - WIN) begin
        // previous window: re-ack only
        push_result(KIND_ACK, p.seq_num, '0);
      end
      if (pending_results.size() > n_before)
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] act);
      if (act !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, act);
        errors++;
      end
    endfunction

    // Called once per accepted result transfer
    function void check_result(out_item_t act);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind=%0b ack=%0d data=%h last=%0b",
                 $time, act.kind, act.ack_num, act.data_out, act.last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, act.kind);
      compare_field("ack_num", want.ack_num, act.ack_num);
      compare_field("data_out", want.data_out, act.data_out);
      compare_field("last", want.last, act.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   idle_cycles = 0;

  arq_scoreboard sb = new();

  srr_chan_if #(.T(in_item_t))  in_ch ();
  srr_chan_if #(.T(out_item_t)) out_ch ();

  selective_repeat_receiver_unit #(
    .WINDOW    (WIN),
    .SEQ_SPACE (SPACE)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic in_item_t make_packet(int seq, bit ok, logic [DATA_W-1:0] word);
    in_item_t p;
    p.seq_num     = SEQ_W'(seq);
    p.checksum_ok = ok;
    p.payload     = word;
    return p;
  endfunction

  // Mostly a sender working the current window, plus retransmits and noise
  function automatic in_item_t random_packet();
    int       pick;
    in_item_t p;
    pick          = $urandom_range(0, 99);
    p.payload     = {$urandom, $urandom};
    p.checksum_ok = 1'b1;
    if ($urandom_range(0, 19) == 0) p.payload = $urandom_range(0, 1) ? '1 : '0;
    if (pick < 65) begin
      p.seq_num = SEQ_W'((sb.rx_base + $urandom_range(0, WIN - 1)) % SPACE);
    end else if (pick < 80) begin
      p.seq_num = SEQ_W'((sb.rx_base + SPACE - 1 - $urandom_range(0, WIN - 1)) % SPACE);
    end else if (pick < 90) begin
      p.seq_num     = SEQ_W'($urandom_range(0, SPACE - 1));
      p.checksum_ok = 1'b0;
    end else begin
      p.seq_num = SEQ_W'($urandom_range(0, SPACE - 1));
    end
    return p;
  endfunction

  // Drive one packet, hold until transferred, then note it
  task automatic send_packet(in_item_t p, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_packet(p);
  endtask

  // Result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        hold = idle_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // base 1: bad checksum on base, then fill 2..4 out of order
    send_packet(make_packet(1, 1'b0, '1), 0);
    send_packet(make_packet(3, 1'b1, '1), 0);
    send_packet(make_packet(2, 1'b1, '0), 0);
    send_packet(make_packet(4, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5), 2);
    // duplicate keeps the first payload
    send_packet(make_packet(4, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A), 0);
    // base hit releases a full window
    send_packet(make_packet(1, 1'b1, 64'h1), 0);
    // base 5: previous window re-acks
    send_packet(make_packet(1, 1'b1, 64'h1111), 0);
    send_packet(make_packet(4, 1'b1, 64'h4444), 0);
    // window wraps through 0
    send_packet(make_packet(0, 1'b1, 64'h8000_0000_0000_0000), 0);
    send_packet(make_packet(7, 1'b1, 64'h0123_4567_89AB_CDEF), 0);
    send_packet(make_packet(6, 1'b1, 64'hFEDC_BA98_7654_3210), 3);
    send_packet(make_packet(7, 1'b0, '0), 0);
    send_packet(make_packet(5, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF), 0);
    // base 1 again
    send_packet(make_packet(0, 1'b0, '1), 0);
    send_packet(make_packet(1, 1'b1, '1), 0);
    send_packet(make_packet(2, 1'b1, '0), 0);

    // random phases with varying idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      gap_pct   = PHASE_GAP[ph];
      stall_pct = PHASE_STALL[ph];
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_packet(random_packet(), ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0);
    end
    in_ch.valid <= 1'b0;

    // drain and let the block settle
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
